>>> design/pdtt_pkg.sv
// Shared types and constants for the periodic deadline timer table.
package pdtt_pkg;

	localparam int Capacity = 16;
	localparam int CntW = (Capacity > 1) ? $clog2(Capacity) : 1;
	localparam logic [62:0] TimeMax = '1;

	typedef enum logic [2:0] {
		OP_REGISTER   = 3'd0,
		OP_UNREGISTER = 3'd1,
		OP_SET_ENABLE = 3'd2,
		OP_TICK       = 3'd3,
		OP_QUERY      = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDIV,
		S_EDIT,
		S_SCAN,
		S_TDIV,
		S_EMIT,
		S_FINAL
	} state_t;

	// One table entry as held in a cell; fired/late/sched carry a tick result
	typedef struct packed {
		logic        valid;
		logic [31:0] handle;
		logic [31:0] interval;
		logic [31:0] limit;
		logic [62:0] trig;
		logic        enabled;
		logic        fired;
		logic        late;
		logic [62:0] sched;
	} entry_t;

	// Per-cycle commands broadcast to every cell
	typedef struct packed {
		logic        rotate;
		logic        remove;
		logic        insert;
		logic        set_en;
		logic        en_val;
		logic [31:0] tgt;
	} cell_ctrl_t;

endpackage

>>> design/periodic_deadline_timer_table.sv
// Top level of the periodic deadline timer table: sequencer, cell row and divider.
//
//  channel | signals                         | direction | request
//  in      | in_valid / in_stall             | into block | one operation
//  out     | out_valid / out_stall           | out of block | one result
//  cfg     | cfg_valid / cfg_ready           | into block | abort_on_miss write
//
// Query, unknown operation and failed register go straight to the final result.
// Unregister and set enable edit the row, then make one refresh pass over it.
// Register runs the divider, inserts the entry, then makes a refresh pass.
// Tick scans the row, running the divider for each due entry, then emits firings.
// Reset clears all valid bits at once; no clearing pass. Output stalls hold
// the result register and the sequencer; input is taken only when idle.
module periodic_deadline_timer_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [62:0] now_us,
	input  logic [31:0] interval_us,
	input  logic [31:0] lateness_limit_us,
	input  logic [31:0] target_handle,
	input  logic        enable_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_handle,
	output logic [62:0] scheduled_us,
	output logic        is_firing,
	output logic        late,
	output logic        abort_request,
	output logic        ok,
	output logic [62:0] next_deadline_us,
	output logic        any_active,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        abort_on_miss
);

	localparam int Cap = pdtt_pkg::Capacity;

	pdtt_pkg::state_t     state_q, state_n;
	pdtt_pkg::cell_ctrl_t ctrl;
	pdtt_pkg::entry_t     ent [Cap];
	pdtt_pkg::entry_t     new_ent;
	pdtt_pkg::entry_t     head;
	pdtt_pkg::entry_t     proc;
	pdtt_pkg::entry_t     tail;
	logic [Cap-1:0]       match;

	logic [2:0]           op_q;
	logic [62:0]          now_q;
	logic [31:0]          ivl_q;
	logic [31:0]          lim_q;
	logic [31:0]          tgt_q;
	logic                 en_q;
	logic                 abort_q;
	logic [31:0]          hcnt_q;
	logic [62:0]          min_q;
	logic                 act_q;
	logic [62:0]          acc_min_q, acc_min_n;
	logic                 acc_act_q, acc_act_n;
	logic [pdtt_pkg::CntW-1:0] cnt_q;
	logic                 rem_ok_q;
	logic                 ok_q;
	logic [31:0]          res_h_q;

	logic                 accept;
	logic                 out_free;
	logic                 full;
	logic                 is_tick;
	logic                 due;
	logic [62:0]          lateness;
	logic                 late_c;
	logic [31:0]          addend;
	logic [63:0]          trig_sum;
	logic [62:0]          new_trig;
	logic                 div_start;
	logic                 div_done;
	logic [62:0]          div_dvd;
	logic [31:0]          div_dsr;
	logic [31:0]          div_rem;
	logic                 rotate;
	logic                 cnt_end;
	logic                 emit_fire;
	logic                 emit_final;
	logic                 prefix_ok;

	logic                 ov_q;
	logic [31:0]          o_handle_q;
	logic [62:0]          o_sched_q;
	logic                 o_fire_q;
	logic                 o_late_q;
	logic                 o_abort_q;
	logic                 o_ok_q;
	logic [62:0]          o_next_q;
	logic                 o_act_q;
	logic                 o_last_q;

	// Cell row
	for (genvar i = 0; i < Cap; i++) begin : g_cell
		pdtt_pkg::entry_t c_nbr;
		logic             c_left;
		logic             c_min;
		if (i == Cap - 1) begin : g_tail
			assign c_nbr = tail;
		end else begin : g_mid
			assign c_nbr = ent[i+1];
		end
		if (i == 0) begin : g_first
			assign c_left = 1'b1;
			assign c_min  = 1'b0;
		end else begin : g_rest
			assign c_left = ent[i-1].valid;
			assign c_min  = match[i-1];
		end
		pdtt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.nbr        (c_nbr),
			.new_ent    (new_ent),
			.left_valid (c_left),
			.match_in   (c_min),
			.ent        (ent[i]),
			.match_out  (match[i])
		);
	end

	pdtt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.rem      (div_rem)
	);

	// Handshake basics
	always_comb begin
		in_stall  = (state_q != pdtt_pkg::S_IDLE);
		accept    = in_valid && !in_stall;
		out_free  = !ov_q || !out_stall;
		cfg_ready = 1'b1;
		full      = ent[Cap-1].valid;
		is_tick   = (op_q == pdtt_pkg::OP_TICK);
	end

	// Head entry evaluation and trigger realignment
	always_comb begin
		head     = ent[0];
		due      = is_tick && head.valid && head.enabled && (now_q >= head.trig);
		lateness = now_q - head.trig;
		late_c   = (head.limit != 32'd0) && (lateness > {31'd0, head.limit});
		addend   = (state_q == pdtt_pkg::S_RDIV) ? ivl_q : head.interval;
		trig_sum = {1'b0, now_q} - {32'd0, div_rem} + {32'd0, addend};
		new_trig = trig_sum[63] ? pdtt_pkg::TimeMax : trig_sum[62:0];
	end

	// Entry going back into the tail
	always_comb begin
		proc       = head;
		proc.fired = 1'b0;
		if (state_q == pdtt_pkg::S_SCAN && due) begin
			proc.fired = 1'b1;
			proc.late  = late_c;
			proc.sched = head.trig;
			proc.trig  = new_trig;
		end
		tail = ctrl.remove ? '0 : proc;
	end

	// Entry built on register
	always_comb begin
		new_ent          = '0;
		new_ent.valid    = 1'b1;
		new_ent.handle   = hcnt_q;
		new_ent.interval = ivl_q;
		new_ent.limit    = lim_q;
		new_ent.trig     = new_trig;
		new_ent.enabled  = 1'b1;
	end

	// Running minimum over entries passing the tail
	always_comb begin
		acc_act_n = acc_act_q;
		acc_min_n = acc_min_q;
		if (tail.valid && tail.enabled) begin
			acc_act_n = 1'b1;
			if (tail.trig < acc_min_q) begin
				acc_min_n = tail.trig;
			end
		end
	end

	// Sequencer strobes
	always_comb begin
		div_start   = 1'b0;
		div_dvd     = lateness;
		div_dsr     = head.interval;
		rotate      = 1'b0;
		ctrl        = '0;
		ctrl.tgt    = tgt_q;
		ctrl.en_val = en_q;
		emit_fire   = 1'b0;
		emit_final  = 1'b0;
		unique case (state_q)
			pdtt_pkg::S_IDLE: begin
				div_dvd = now_us;
				div_dsr = interval_us;
				div_start = accept && (operation == pdtt_pkg::OP_REGISTER)
					&& (interval_us != 32'd0) && !full;
			end
			pdtt_pkg::S_RDIV: begin
				ctrl.insert = div_done;
			end
			pdtt_pkg::S_EDIT: begin
				ctrl.remove = (op_q == pdtt_pkg::OP_UNREGISTER);
				ctrl.set_en = (op_q == pdtt_pkg::OP_SET_ENABLE);
			end
			pdtt_pkg::S_SCAN: begin
				div_start = due && !rem_ok_q;
				rotate    = !due || rem_ok_q;
			end
			pdtt_pkg::S_TDIV: begin
			end
			pdtt_pkg::S_EMIT: begin
				emit_fire = head.fired && out_free;
				rotate    = !head.fired || out_free;
			end
			pdtt_pkg::S_FINAL: begin
				emit_final = out_free;
			end
			default: begin
			end
		endcase
		ctrl.rotate = rotate;
		cnt_end     = rotate && (cnt_q == pdtt_pkg::CntW'(Cap - 1));
	end

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			pdtt_pkg::S_IDLE: begin
				if (accept) begin
					priority case (operation)
						pdtt_pkg::OP_REGISTER:
							state_n = div_start ? pdtt_pkg::S_RDIV : pdtt_pkg::S_FINAL;
						pdtt_pkg::OP_UNREGISTER, pdtt_pkg::OP_SET_ENABLE:
							state_n = pdtt_pkg::S_EDIT;
						pdtt_pkg::OP_TICK:
							state_n = pdtt_pkg::S_SCAN;
						default:
							state_n = pdtt_pkg::S_FINAL;
					endcase
				end
			end
			pdtt_pkg::S_RDIV: begin
				if (div_done) state_n = pdtt_pkg::S_SCAN;
			end
			pdtt_pkg::S_EDIT: begin
				state_n = pdtt_pkg::S_SCAN;
			end
			pdtt_pkg::S_SCAN: begin
				if (div_start) begin
					state_n = pdtt_pkg::S_TDIV;
				end else if (cnt_end) begin
					state_n = is_tick ? pdtt_pkg::S_EMIT : pdtt_pkg::S_FINAL;
				end
			end
			pdtt_pkg::S_TDIV: begin
				if (div_done) state_n = pdtt_pkg::S_SCAN;
			end
			pdtt_pkg::S_EMIT: begin
				if (cnt_end) state_n = pdtt_pkg::S_FINAL;
			end
			pdtt_pkg::S_FINAL: begin
				if (emit_final) state_n = pdtt_pkg::S_IDLE;
			end
			default: state_n = pdtt_pkg::S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pdtt_pkg::S_IDLE;
			abort_q   <= 1'b0;
			hcnt_q    <= 32'd1;
			min_q     <= pdtt_pkg::TimeMax;
			act_q     <= 1'b0;
			acc_min_q <= pdtt_pkg::TimeMax;
			acc_act_q <= 1'b0;
			cnt_q     <= '0;
			rem_ok_q  <= 1'b0;
			ok_q      <= 1'b0;
			res_h_q   <= '0;
			ov_q      <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_valid) abort_q <= abort_on_miss;

			if (state_q == pdtt_pkg::S_IDLE) begin
				acc_min_q <= pdtt_pkg::TimeMax;
				acc_act_q <= 1'b0;
				cnt_q     <= '0;
				rem_ok_q  <= 1'b0;
			end else if (rotate) begin
				cnt_q    <= cnt_end ? '0 : cnt_q + 1'b1;
				rem_ok_q <= 1'b0;
				if (state_q == pdtt_pkg::S_SCAN) begin
					acc_min_q <= acc_min_n;
					acc_act_q <= acc_act_n;
				end
			end else if (state_q == pdtt_pkg::S_TDIV && div_done) begin
				rem_ok_q <= 1'b1;
			end

			if (state_q == pdtt_pkg::S_SCAN && cnt_end) begin
				min_q <= acc_min_n;
				act_q <= acc_act_n;
			end

			// Summary result bookkeeping
			if (accept) begin
				ok_q    <= (operation == pdtt_pkg::OP_QUERY) && act_q && (now_us >= min_q);
				res_h_q <= '0;
			end else if (state_q == pdtt_pkg::S_EDIT) begin
				ok_q <= match[Cap-1];
			end else if (state_q == pdtt_pkg::S_RDIV && div_done) begin
				ok_q    <= 1'b1;
				res_h_q <= hcnt_q;
				hcnt_q  <= (hcnt_q == '1) ? 32'd1 : hcnt_q + 32'd1;
			end else if (state_q == pdtt_pkg::S_SCAN && due && rotate) begin
				ok_q <= 1'b1;
			end

			if (emit_fire || emit_final) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Operand capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			now_q <= now_us;
			ivl_q <= interval_us;
			lim_q <= lateness_limit_us;
			tgt_q <= target_handle;
			en_q  <= enable_value;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			o_handle_q <= head.handle;
			o_sched_q  <= head.sched;
			o_fire_q   <= 1'b1;
			o_late_q   <= head.late;
			o_abort_q  <= head.late && abort_q;
			o_ok_q     <= 1'b1;
			o_next_q   <= min_q;
			o_act_q    <= act_q;
			o_last_q   <= 1'b0;
		end else if (emit_final) begin
			o_handle_q <= res_h_q;
			o_sched_q  <= '0;
			o_fire_q   <= 1'b0;
			o_late_q   <= 1'b0;
			o_abort_q  <= 1'b0;
			o_ok_q     <= ok_q;
			o_next_q   <= min_q;
			o_act_q    <= act_q;
			o_last_q   <= 1'b1;
		end
	end

	assign out_valid        = ov_q;
	assign result_handle    = o_handle_q;
	assign scheduled_us     = o_sched_q;
	assign is_firing        = o_fire_q;
	assign late             = o_late_q;
	assign abort_request    = o_abort_q;
	assign ok               = o_ok_q;
	assign next_deadline_us = o_next_q;
	assign any_active       = o_act_q;
	assign last             = o_last_q;

	// Valid entries must form a prefix of the row
	always_comb begin
		prefix_ok = 1'b1;
		for (int i = 0; i < Cap - 1; i++) begin
			if (ent[i+1].valid && !ent[i].valid) prefix_ok = 1'b0;
		end
	end

	prefix_a: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pdtt_pkg::S_IDLE |-> prefix_ok) else $error("table has a gap");
	idle_min_a: assert property (@(posedge clk) disable iff (!arst_n)
		!act_q |-> min_q == pdtt_pkg::TimeMax) else $error("deadline without active entry");
	fire_not_last_a: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && o_fire_q |-> !o_last_q) else $error("firing marked last");
	busy_after_accept_a: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != pdtt_pkg::S_IDLE) else $error("request dropped");

endmodule

>>> design/pdtt_div.sv
// Bit-serial restoring divider giving the remainder of a 63-bit value by a 32-bit value.
module pdtt_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [62:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] rem
);

	logic [62:0] dvd_q;
	logic [31:0] dsr_q;
	logic [31:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] diff;

	// One quotient bit per cycle
	always_comb begin
		trial = {rem_q, dvd_q[62]};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd62) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[61:0], 1'b0};
			rem_q <= diff[32] ? trial[31:0] : diff[31:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	cnt_range_a: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q <= 6'd62) else $error("divider count overrun");
	done_after_busy_a: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	start_clears_done_a: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !done_q) else $error("divider done right after start");

endmodule

>>> design/pdtt_cell.sv
// One table cell: holds an entry, shifts from its right neighbor, inserts and edits.
module pdtt_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pdtt_pkg::cell_ctrl_t   ctrl,
	input  pdtt_pkg::entry_t       nbr,
	input  pdtt_pkg::entry_t       new_ent,
	input  logic                   left_valid,
	input  logic                   match_in,
	output pdtt_pkg::entry_t       ent,
	output logic                   match_out
);

	logic             valid_q;
	logic             fired_q;
	pdtt_pkg::entry_t pay_q;
	pdtt_pkg::entry_t cur;
	pdtt_pkg::entry_t nxt;
	logic             mine;
	logic             take;
	logic             load;
	logic             hit;

	// Current entry view
	always_comb begin
		cur       = pay_q;
		cur.valid = valid_q;
		cur.fired = fired_q;
	end

	// Handle match chain: first match in table order wins
	always_comb begin
		mine      = valid_q && (pay_q.handle == ctrl.tgt) && (ctrl.tgt != 32'd0);
		match_out = match_in || mine;
		take      = ctrl.rotate || (ctrl.remove && match_out);
		load      = ctrl.insert && !valid_q && left_valid;
		hit       = ctrl.set_en && mine && !match_in;
	end

	// Next entry
	always_comb begin
		if (take) begin
			nxt = nbr;
		end else if (load) begin
			nxt = new_ent;
		end else begin
			nxt = cur;
		end
		if (hit) begin
			nxt.enabled = ctrl.en_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			fired_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
			fired_q <= nxt.fired;
		end
	end

	always_ff @(posedge clk) begin
		pay_q <= nxt;
	end

	assign ent = cur;

endmodule
